/* sv/affc_pkg.sv */
// Shared types, constants and the inverse table builder for the affine cipher.
// Used by affc_modred and affine_cipher_printable_ascii; depends on nothing.
`timescale 1ns / 1ps

package affc_pkg;

  localparam logic [7:0] ALPHA_FIRST = 8'd32;
  localparam logic [7:0] ALPHA_LAST  = 8'd126;
  localparam logic [6:0] ALPHA_SIZE  = 7'd95;

  localparam logic [9:0] RECIP_K     = 10'd689;
  localparam int         RECIP_SHIFT = 16;

  localparam logic CMD_ENC = 1'b0;
  localparam logic CMD_DEC = 1'b1;

  localparam logic REG_KEY_MULT = 1'b0;
  localparam logic REG_KEY_ADD  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_NO_INV   = 2'd2
  } status_t;

  typedef struct packed {
    logic    vld;
    status_t status;
  } tag_t;

  typedef logic [6:0] inv_tbl_t [95];

  function automatic inv_tbl_t build_inv_tbl();
    inv_tbl_t tbl;
    for (int a = 0; a < 95; a++) begin
      tbl[a] = 7'd0;
      for (int x = 1; x < 95; x++) begin
        if ((a * x) % 95 == 1) begin
          tbl[a] = 7'(x);
        end
      end
    end
    return tbl;
  endfunction

endpackage

/* sv/affc_modred.sv */
// Two-stage reduction of a 14-bit product modulo 95 by reciprocal multiply.
// Depends on affc_pkg.
`timescale 1ns / 1ps

module affc_modred (
  input  logic              clk,
  input  logic              rst_n,
  input  affc_pkg::tag_t    in_tag,
  input  logic [13:0]       in_prod,
  output affc_pkg::tag_t    out_tag,
  output logic [6:0]        out_rem
);

  logic           q_vld_r;
  affc_pkg::status_t q_status_r;
  logic [13:0]    q_prod_r;
  logic [6:0]     q_quot_r;
  logic [23:0]    quot_full;
  logic [6:0]     quot_nxt;

  logic           r_vld_r;
  affc_pkg::status_t r_status_r;
  logic [6:0]     r_rem_r;
  logic [13:0]    qx95;
  logic [13:0]    rem_full;
  logic [7:0]     rem8;
  logic [7:0]     rem_fix;

  // estimate quotient, may be one low
  assign quot_full = {10'd0, in_prod} * {14'd0, affc_pkg::RECIP_K};
  assign quot_nxt  = quot_full[affc_pkg::RECIP_SHIFT +: 7];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_vld_r <= 1'b0;
    end else begin
      q_vld_r <= in_tag.vld;
    end
    q_status_r <= in_tag.status;
    q_prod_r   <= in_prod;
    q_quot_r   <= quot_nxt;
  end

  // subtract and correct once
  assign qx95     = {7'd0, q_quot_r} * {7'd0, affc_pkg::ALPHA_SIZE};
  assign rem_full = q_prod_r - qx95;
  assign rem8     = rem_full[7:0];
  assign rem_fix  = (rem8 >= {1'b0, affc_pkg::ALPHA_SIZE}) ?
                    rem8 - {1'b0, affc_pkg::ALPHA_SIZE} : rem8;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_vld_r <= 1'b0;
    end else begin
      r_vld_r <= q_vld_r;
    end
    r_status_r <= q_status_r;
    r_rem_r    <= rem_fix[6:0];
  end

  assign out_tag.vld    = r_vld_r;
  assign out_tag.status = r_status_r;
  assign out_rem        = r_rem_r;

endmodule

/* sv/affine_cipher_printable_ascii.sv */
// Top level of the affine cipher over printable ASCII: key registers and pipeline.
// Depends on affc_pkg and affc_modred.
`timescale 1ns / 1ps

//  channel | ports                                   | handshake
//  --------+-----------------------------------------+----------------------------
//  input   | in_command, in_char_in                  | start high, busy low
//  result  | out_char_out, out_status                | out_strobe, one cycle
//  config  | cfg_index, cfg_data                     | cfg_we, written at once
//
//  One item per cycle; each result passes through five register stages: key prep,
//  operand prep, multiply-add, quotient estimate, remainder correction.
//  Reset clears the valid bits and sets key_mult to 1 and key_add to 0.
//  busy stays low; the receiver cannot stall, so nothing is held back.

module affine_cipher_printable_ascii (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_command,
  input  logic [7:0] in_char_in,
  output logic       out_strobe,
  output logic [7:0] out_char_out,
  output logic [1:0] out_status,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data
);

  localparam affc_pkg::inv_tbl_t INV_TBL = affc_pkg::build_inv_tbl();
  localparam int LATENCY = 5;

  logic [6:0] key_mult_r;
  logic [6:0] key_add_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_mult_r <= 7'd1;
      key_add_r  <= 7'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        affc_pkg::REG_KEY_MULT: key_mult_r <= cfg_data;
        affc_pkg::REG_KEY_ADD:  key_add_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 1: reduce keys, check range, look up inverse
  logic [6:0]        a_red;
  logic [6:0]        b_red;
  logic [6:0]        inv_val;
  logic              in_range;
  logic              accept;
  affc_pkg::status_t s1_status_nxt;

  logic              s1_vld_r;
  affc_pkg::status_t s1_status_r;
  logic              s1_dec_r;
  logic [6:0]        s1_x_r;
  logic [6:0]        s1_m1_r;
  logic [6:0]        s1_b_r;

  assign accept   = start & ~busy;
  assign a_red    = (key_mult_r >= affc_pkg::ALPHA_SIZE) ?
                    key_mult_r - affc_pkg::ALPHA_SIZE : key_mult_r;
  assign b_red    = (key_add_r >= affc_pkg::ALPHA_SIZE) ?
                    key_add_r - affc_pkg::ALPHA_SIZE : key_add_r;
  assign inv_val  = INV_TBL[a_red];
  assign in_range = (in_char_in >= affc_pkg::ALPHA_FIRST) &&
                    (in_char_in <= affc_pkg::ALPHA_LAST);

  always_comb begin
    if (!in_range) begin
      s1_status_nxt = affc_pkg::ST_BAD_CHAR;
    end else if (in_command == affc_pkg::CMD_DEC && inv_val == 7'd0) begin
      s1_status_nxt = affc_pkg::ST_NO_INV;
    end else begin
      s1_status_nxt = affc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
    s1_status_r <= s1_status_nxt;
    s1_dec_r    <= (in_command == affc_pkg::CMD_DEC);
    s1_x_r      <= 7'(in_char_in - affc_pkg::ALPHA_FIRST);
    s1_m1_r     <= (in_command == affc_pkg::CMD_DEC) ? inv_val : a_red;
    s1_b_r      <= b_red;
  end

  // stage 2: form operands
  logic [6:0]        diff;
  logic [7:0]        diff_wrap;

  logic              s2_vld_r;
  affc_pkg::status_t s2_status_r;
  logic [6:0]        s2_m1_r;
  logic [6:0]        s2_m2_r;
  logic [6:0]        s2_add_r;

  assign diff_wrap = ({1'b0, s1_x_r} + {1'b0, affc_pkg::ALPHA_SIZE}) - {1'b0, s1_b_r};
  assign diff      = (s1_x_r >= s1_b_r) ? s1_x_r - s1_b_r : diff_wrap[6:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_status_r <= s1_status_r;
    s2_m1_r     <= s1_m1_r;
    s2_m2_r     <= s1_dec_r ? diff : s1_x_r;
    s2_add_r    <= s1_dec_r ? 7'd0 : s1_b_r;
  end

  // stage 3: multiply-add
  affc_pkg::tag_t s3_tag;
  logic           s3_vld_r;
  affc_pkg::status_t s3_status_r;
  logic [13:0]    s3_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    s3_status_r <= s2_status_r;
    s3_prod_r   <= ({7'd0, s2_m1_r} * {7'd0, s2_m2_r}) + {7'd0, s2_add_r};
  end

  assign s3_tag.vld    = s3_vld_r;
  assign s3_tag.status = s3_status_r;

  // stages 4 and 5: reduce mod 95
  affc_pkg::tag_t red_tag;
  logic [6:0]     red_rem;

  affc_modred u_modred (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tag  (s3_tag),
    .in_prod (s3_prod_r),
    .out_tag (red_tag),
    .out_rem (red_rem)
  );

  assign out_strobe   = red_tag.vld;
  assign out_status   = red_tag.status;
  assign out_char_out = (red_tag.status == affc_pkg::ST_OK) ?
                        {1'b0, red_rem} + affc_pkg::ALPHA_FIRST : 8'd0;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_strobe)
    else $error("item did not come out after the pipeline latency");

  a_printable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == affc_pkg::ST_OK) |->
      (out_char_out >= affc_pkg::ALPHA_FIRST && out_char_out <= affc_pkg::ALPHA_LAST))
    else $error("ok result outside printable range");

  a_noinv_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == affc_pkg::ST_NO_INV) |->
      $past(in_command, LATENCY) == affc_pkg::CMD_DEC)
    else $error("missing-inverse status on an encipher item");

endmodule
